// ===== src/fwpd_pkg.sv =====
package fwpd_pkg;

  // encoder and target width
  localparam int unsigned POS_BITS   = 24;
  localparam int unsigned NUM_WHEELS = 4;
  // quotient bits: power magnitude is at most 127
  localparam int unsigned Q_BITS     = 7;
  localparam int unsigned QIDX_W     = $clog2(Q_BITS);
  localparam int unsigned DRV_W      = Q_BITS + 1;
  // numerator width: distance times base power
  localparam int unsigned NUM_W      = POS_BITS + Q_BITS;
  localparam int unsigned BP_W       = 7;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CFG_W      = (POS_BITS > THR_W) ? POS_BITS : THR_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [BP_W-1:0]  BASE_POWER_RST = BP_W'(50);
  localparam logic [THR_W-1:0] THRESHOLD_RST  = THR_W'(100);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_POWER = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_TGT_FL     = 3'd2,
    CFG_TGT_FR     = 3'd3,
    CFG_TGT_BL     = 3'd4,
    CFG_TGT_BR     = 3'd5
  } cfg_idx_e;

  // input request: one set of encoder samples
  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_front_left;
    logic signed [POS_BITS-1:0] pos_front_right;
    logic signed [POS_BITS-1:0] pos_back_left;
    logic signed [POS_BITS-1:0] pos_back_right;
  } fwpd_req_t;

  // result: four drive commands and done flag
  typedef struct packed {
    logic signed [DRV_W-1:0] drive_front_left;
    logic signed [DRV_W-1:0] drive_front_right;
    logic signed [DRV_W-1:0] drive_back_left;
    logic signed [DRV_W-1:0] drive_back_right;
    logic                    done_res;
  } fwpd_res_t;

  // distances after the first front stage
  typedef struct packed {
    logic [NUM_WHEELS-1:0][POS_BITS-1:0] wdist;
    logic [NUM_WHEELS-1:0]               below;
  } fwpd_dist_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [NUM_WHEELS-1:0][NUM_W-1:0] num;
    logic [POS_BITS-1:0]              dmax;
    logic [NUM_WHEELS-1:0]            below;
    logic                             all_in;
    logic                             zero_mag;
  } fwpd_job_t;

  // divider stage contents
  typedef struct packed {
    logic [NUM_WHEELS-1:0][NUM_W-1:0]  rem;
    logic [NUM_WHEELS-1:0][Q_BITS-1:0] quo;
    logic [POS_BITS-1:0]               dmax;
    logic [NUM_WHEELS-1:0]             below;
    logic                              all_in;
    logic                              zero_mag;
  } fwpd_div_t;

  // one restoring division step on all four wheels
  function automatic fwpd_div_t div_step(fwpd_div_t s, logic [QIDX_W-1:0] k);
    fwpd_div_t        r;
    logic [NUM_W-1:0] sub;
    r   = s;
    sub = NUM_W'(s.dmax) << k;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (s.rem[w] >= sub) begin
        r.rem[w]    = s.rem[w] - sub;
        r.quo[w][k] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/fwpd_front.sv =====
module fwpd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fwpd_pkg::fwpd_req_t                 in_req_i,
  input  logic                                cfg_we_i,
  input  logic [fwpd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fwpd_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                                job_valid_o,
  output fwpd_pkg::fwpd_job_t                 job_o,
  input  logic                                job_full_i
);
  import fwpd_pkg::*;

  logic [BP_W-1:0]                     base_power_q;
  logic [THR_W-1:0]                    threshold_q;
  logic [NUM_WHEELS-1:0][POS_BITS-1:0] tgt_q;

  logic [NUM_WHEELS-1:0][POS_BITS-1:0] pos;
  fwpd_dist_t                          s1_d;
  fwpd_dist_t                          s1_q;
  logic                                s1_valid_q;
  fwpd_job_t                           s2_d;
  fwpd_job_t                           s2_q;
  logic                                s2_valid_q;
  logic                                adv1;
  logic                                adv2;
  logic [POS_BITS-1:0]                 max01;
  logic [POS_BITS-1:0]                 max23;
  logic [NUM_WHEELS-1:0]               arrived;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_power_q <= BASE_POWER_RST;
      threshold_q  <= THRESHOLD_RST;
      tgt_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_POWER: base_power_q <= cfg_data_i[BP_W-1:0];
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i[THR_W-1:0];
        CFG_TGT_FL:     tgt_q[0]     <= cfg_data_i[POS_BITS-1:0];
        CFG_TGT_FR:     tgt_q[1]     <= cfg_data_i[POS_BITS-1:0];
        CFG_TGT_BL:     tgt_q[2]     <= cfg_data_i[POS_BITS-1:0];
        CFG_TGT_BR:     tgt_q[3]     <= cfg_data_i[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // wheel order: front left, front right, back left, back right
  assign pos[0] = in_req_i.pos_front_left;
  assign pos[1] = in_req_i.pos_front_right;
  assign pos[2] = in_req_i.pos_back_left;
  assign pos[3] = in_req_i.pos_back_right;

  // stall chain
  assign adv2       = !s2_valid_q || !job_full_i;
  assign adv1       = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;

  // distance and direction per wheel
  always_comb begin
    logic signed [POS_BITS:0] pe;
    logic signed [POS_BITS:0] te;
    logic        [POS_BITS:0] diff;
    s1_d = '0;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      pe = {pos[w][POS_BITS-1], pos[w]};
      te = {tgt_q[w][POS_BITS-1], tgt_q[w]};
      s1_d.below[w] = te < pe;
      diff = s1_d.below[w] ? (pe - te) : (te - pe);
      s1_d.wdist[w] = diff[POS_BITS-1:0];
    end
  end

  // largest distance, arrival and scaled numerators
  always_comb begin
    max01 = (s1_q.wdist[0] > s1_q.wdist[1]) ? s1_q.wdist[0] : s1_q.wdist[1];
    max23 = (s1_q.wdist[2] > s1_q.wdist[3]) ? s1_q.wdist[2] : s1_q.wdist[3];
    for (int w = 0; w < NUM_WHEELS; w++) begin
      arrived[w] = CFG_W'(s1_q.wdist[w]) < CFG_W'(threshold_q);
    end
    s2_d.dmax  = (max01 > max23) ? max01 : max23;
    s2_d.below = s1_q.below;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      s2_d.num[w] = NUM_W'(s1_q.wdist[w]) * NUM_W'(base_power_q);
    end
    s2_d.all_in   = &arrived;
    s2_d.zero_mag = (&arrived) || (s2_d.dmax == '0);
  end

  // front pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  // front pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) s1_q <= s1_d;
    if (adv2 && s1_valid_q) s2_q <= s2_d;
  end

  assign job_valid_o = s2_valid_q;
  assign job_o       = s2_q;

endmodule

// ===== src/fwpd_queue.sv =====
module fwpd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fwpd_pkg::fwpd_job_t data_i,
  output logic                full_o,
  output logic                valid_o,
  output fwpd_pkg::fwpd_job_t data_o,
  input  logic                pop_i
);
  import fwpd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  fwpd_job_t        ent_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_ptr_q] <= data_i;
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |=> push_i && $stable(data_i))
    else $error("stalled push dropped or changed");
  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not drain an entry");

endmodule

// ===== src/fwpd_back.sv =====
module fwpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  fwpd_pkg::fwpd_job_t job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  output fwpd_pkg::fwpd_res_t out_res_o,
  input  logic                out_stall_i
);
  import fwpd_pkg::*;

  localparam int unsigned LAST = Q_BITS - 1;

  fwpd_div_t            st_q   [Q_BITS];
  fwpd_div_t            st_in  [Q_BITS];
  fwpd_div_t            st_nxt [Q_BITS];
  logic [Q_BITS-1:0]    st_valid_q;
  logic [Q_BITS:0]      adv;
  logic                 out_valid_q;
  fwpd_res_t            out_q;
  fwpd_res_t            out_d;
  logic [NUM_WHEELS-1:0][DRV_W-1:0] drv;

  // stall chain from the output register back to the queue head
  always_comb begin
    adv[Q_BITS] = !out_valid_q || !out_stall_i;
    for (int s = Q_BITS - 1; s >= 0; s--) begin
      adv[s] = !st_valid_q[s] || adv[s+1];
    end
  end

  assign job_pop_o = adv[0] && job_valid_i;

  // one quotient bit per stage, most significant first
  always_comb begin
    st_in[0].rem      = job_i.num;
    st_in[0].quo      = '0;
    st_in[0].dmax     = job_i.dmax;
    st_in[0].below    = job_i.below;
    st_in[0].all_in   = job_i.all_in;
    st_in[0].zero_mag = job_i.zero_mag;
    for (int s = 1; s < Q_BITS; s++) begin
      st_in[s] = st_q[s-1];
    end
    for (int s = 0; s < Q_BITS; s++) begin
      st_nxt[s] = div_step(st_in[s], QIDX_W'(Q_BITS - 1 - s));
    end
  end

  // divider valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else begin
      if (adv[0]) st_valid_q[0] <= job_valid_i;
      for (int s = 1; s < Q_BITS; s++) begin
        if (adv[s]) st_valid_q[s] <= st_valid_q[s-1];
      end
    end
  end

  // divider payload
  always_ff @(posedge clk_i) begin
    if (adv[0] && job_valid_i) st_q[0] <= st_nxt[0];
    for (int s = 1; s < Q_BITS; s++) begin
      if (adv[s] && st_valid_q[s-1]) st_q[s] <= st_nxt[s];
    end
  end

  // apply direction, clear power when all wheels have arrived or the largest distance is zero
  always_comb begin
    logic [Q_BITS-1:0] mag;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      mag    = st_q[LAST].zero_mag ? '0 : st_q[LAST].quo[w];
      drv[w] = st_q[LAST].below[w] ? DRV_W'(-{1'b0, mag}) : {1'b0, mag};
    end
    out_d.drive_front_left  = drv[0];
    out_d.drive_front_right = drv[1];
    out_d.drive_back_left   = drv[2];
    out_d.drive_back_right  = drv[3];
    out_d.done_res          = st_q[LAST].all_in;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv[Q_BITS]) begin
      out_valid_q <= st_valid_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[Q_BITS] && st_valid_q[LAST]) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // checks
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |->
      out_q.drive_front_left == '0 && out_q.drive_front_right == '0 &&
      out_q.drive_back_left == '0 && out_q.drive_back_right == '0)
    else $error("done request with nonzero drive");
  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid_q[LAST] && adv[Q_BITS] |=> out_valid_q)
    else $error("divider result lost before output register");
  a_arrive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid_q[LAST] && st_q[LAST].all_in |-> st_q[LAST].zero_mag)
    else $error("arrival without power clear");

endmodule

// ===== src/four_wheel_proportional_drive_core.sv =====
// throughput: one request per cycle while out_stall_i is low, through the 7-stage quotient pipeline
// front: distance stage, max/multiply stage; 2-entry queue; back: 7 divider
// stages and an output register
// reset: base power 50, threshold 100, targets 0, all pipelines and queue empty
module four_wheel_proportional_drive_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fwpd_pkg::fwpd_req_t            in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fwpd_pkg::fwpd_res_t            out_res_o,
  input  logic                           cfg_we_i,
  input  logic [fwpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fwpd_pkg::CFG_W-1:0]     cfg_data_i
);
  import fwpd_pkg::*;

  logic      fr_valid;
  fwpd_job_t fr_job;
  logic      q_full;
  logic      q_valid;
  fwpd_job_t q_job;
  logic      q_pop;

  // request classification
  fwpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (fr_valid),
    .job_o       (fr_job),
    .job_full_i  (q_full)
  );

  // decoupling queue
  fwpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_job),
    .pop_i   (q_pop)
  );

  // scaling divider and result
  fwpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o),
    .out_stall_i (out_stall_i)
  );

endmodule
